// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_ASSERT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/i2r_pkg.sv -----
package i2r_pkg;

	localparam int VALUE_W  = 12;
	localparam int SYMBOL_W = 7;
	localparam int DIGIT_W  = 4;
	localparam int PC_W     = 4;
	// place weight times a digit: 9 * 1000 needs 14 bits
	localparam int MULT_W   = VALUE_W + 2;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

	localparam logic [SYMBOL_W-1:0] SYM_I    = 7'h49;
	localparam logic [SYMBOL_W-1:0] SYM_V    = 7'h56;
	localparam logic [SYMBOL_W-1:0] SYM_X    = 7'h58;
	localparam logic [SYMBOL_W-1:0] SYM_L    = 7'h4C;
	localparam logic [SYMBOL_W-1:0] SYM_C    = 7'h43;
	localparam logic [SYMBOL_W-1:0] SYM_D    = 7'h44;
	localparam logic [SYMBOL_W-1:0] SYM_M    = 7'h4D;
	localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_EXTRACT,
		OP_EMIT,
		OP_ERROR
	} op_t;

	typedef enum logic [1:0] {
		K_UNIT,
		K_FIVE,
		K_TEN
	} kind_t;

	typedef struct packed {
		op_t             op;
		logic [1:0]      place;
		logic [PC_W-1:0] jump;
	} ucode_t;

	localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] PC_ERROR = 4'd9;

	// Control store. Taken jump: ERROR on bad value, IDLE when nothing is left.
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t cw;
		case (pc)
			4'd0:    cw = '{OP_IDLE,    2'd0, PC_ERROR};
			4'd1:    cw = '{OP_EXTRACT, 2'd3, PC_IDLE};
			4'd2:    cw = '{OP_EMIT,    2'd3, PC_IDLE};
			4'd3:    cw = '{OP_EXTRACT, 2'd2, PC_IDLE};
			4'd4:    cw = '{OP_EMIT,    2'd2, PC_IDLE};
			4'd5:    cw = '{OP_EXTRACT, 2'd1, PC_IDLE};
			4'd6:    cw = '{OP_EMIT,    2'd1, PC_IDLE};
			4'd7:    cw = '{OP_EXTRACT, 2'd0, PC_IDLE};
			4'd8:    cw = '{OP_EMIT,    2'd0, PC_IDLE};
			4'd9:    cw = '{OP_ERROR,   2'd0, PC_IDLE};
			default: cw = '{OP_IDLE,    2'd0, PC_ERROR};
		endcase
		return cw;
	endfunction

	function automatic logic [VALUE_W-1:0] place_weight(input logic [1:0] place);
		logic [VALUE_W-1:0] w;
		case (place)
			2'd3:    w = 12'd1000;
			2'd2:    w = 12'd100;
			2'd1:    w = 12'd10;
			default: w = 12'd1;
		endcase
		return w;
	endfunction

	// Characters in the numeral of one decimal digit.
	function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
		logic [2:0] n;
		case (d)
			4'd1, 4'd5:       n = 3'd1;
			4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
			4'd3, 4'd7:       n = 3'd3;
			4'd8:             n = 3'd4;
			default:          n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic kind_t digit_kind(input logic [DIGIT_W-1:0] d,
					      input logic [1:0] k);
		kind_t r;
		case (d)
			4'd4:                   r = (k == 2'd0) ? K_UNIT : K_FIVE;
			4'd9:                   r = (k == 2'd0) ? K_UNIT : K_TEN;
			4'd5, 4'd6, 4'd7, 4'd8: r = (k == 2'd0) ? K_FIVE : K_UNIT;
			default:                r = K_UNIT;
		endcase
		return r;
	endfunction

	function automatic logic [SYMBOL_W-1:0] symbol_of(input logic [1:0] place,
							   input kind_t kind);
		logic [SYMBOL_W-1:0] s;
		case ({place, kind})
			{2'd0, K_UNIT}: s = SYM_I;
			{2'd0, K_FIVE}: s = SYM_V;
			{2'd0, K_TEN}:  s = SYM_X;
			{2'd1, K_UNIT}: s = SYM_X;
			{2'd1, K_FIVE}: s = SYM_L;
			{2'd1, K_TEN}:  s = SYM_C;
			{2'd2, K_UNIT}: s = SYM_C;
			{2'd2, K_FIVE}: s = SYM_D;
			{2'd2, K_TEN}:  s = SYM_M;
			{2'd3, K_UNIT}: s = SYM_M;
			default:        s = SYM_NONE;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/core/integer_to_roman_encoder_top.sv -----
// Integer to Roman numeral encoder.
//
// Input channel (in_valid/in_ready, value): one transfer per 12-bit integer.
// Output channel (out_valid/out_ready, symbol/last/bad_input): one transfer
// per ASCII character, thousands first; last marks the final character.
// Values of 0 or above 3999 give a single transfer with bad_input and last
// set and symbol 0.
//
// A ten-step microprogram runs the conversion: for each decimal place one
// extract step (compare against the nine multiples of the place weight,
// subtract) and one emit step that repeats once per character. Places that
// run out early are skipped once the remainder is zero.
// One item is in flight; in_ready is high only in the idle step.
// A stalled receiver holds the output register and freezes the sequencer at any step that must load a character.
// Reset (arst_n low) returns the step counter to idle and drops out_valid.
module integer_to_roman_encoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [i2r_pkg::VALUE_W-1:0]   value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [i2r_pkg::SYMBOL_W-1:0]  symbol,
	output logic                          last,
	output logic                          bad_input
);

	// sequencer state
	logic [i2r_pkg::PC_W-1:0]    pc_q, pc_d;
	logic [i2r_pkg::VALUE_W-1:0] rem_q, rem_d;
	logic [i2r_pkg::DIGIT_W-1:0] digit_q, digit_d;
	logic [1:0]                  char_q, char_d;

	// output register
	logic                          out_valid_q;
	logic [i2r_pkg::SYMBOL_W-1:0]  symbol_q;
	logic                          last_q;
	logic                          bad_q;

	i2r_pkg::ucode_t cw;

	logic                          load;
	logic [i2r_pkg::SYMBOL_W-1:0]  ld_symbol;
	logic                          ld_last;
	logic                          ld_bad;
	logic                          can_load;

	// extract datapath
	logic [i2r_pkg::VALUE_W-1:0]   weight;
	logic [i2r_pkg::MULT_W-1:0]    mult [1:9];
	logic [i2r_pkg::DIGIT_W-1:0]   ext_digit;
	logic [i2r_pkg::VALUE_W-1:0]   ext_sub;

	// emit datapath
	logic [2:0]                    len;
	logic                          char_end;

	assign cw       = i2r_pkg::ucode(pc_q);
	assign can_load = !out_valid_q || out_ready;
	assign in_ready = (cw.op == i2r_pkg::OP_IDLE);

	// digit = number of multiples of the weight not above the remainder
	always_comb begin
		weight    = i2r_pkg::place_weight(cw.place);
		ext_digit = '0;
		ext_sub   = '0;
		for (int i = 1; i <= 9; i++) begin
			mult[i] = i2r_pkg::MULT_W'(weight) * i2r_pkg::MULT_W'(i);
			if (i2r_pkg::MULT_W'(rem_q) >= mult[i]) begin
				ext_digit = i2r_pkg::DIGIT_W'(i);
				ext_sub   = mult[i][i2r_pkg::VALUE_W-1:0];
			end
		end
	end

	assign len      = i2r_pkg::digit_len(digit_q);
	assign char_end = (len != 3'd0) && (char_q == 2'(len - 3'd1));

	always_comb begin
		pc_d      = pc_q;
		rem_d     = rem_q;
		digit_d   = digit_q;
		char_d    = char_q;
		load      = 1'b0;
		ld_symbol = i2r_pkg::SYM_NONE;
		ld_last   = 1'b0;
		ld_bad    = 1'b0;
		case (cw.op)
			i2r_pkg::OP_IDLE: begin
				if (in_valid) begin
					rem_d = value;
					if (value == '0 || value > i2r_pkg::VALUE_MAX) begin
						pc_d = cw.jump;
					end else begin
						pc_d = pc_q + 1'b1;
					end
				end
			end
			i2r_pkg::OP_EXTRACT: begin
				digit_d = ext_digit;
				rem_d   = rem_q - ext_sub;
				char_d  = '0;
				pc_d    = pc_q + 1'b1;
			end
			i2r_pkg::OP_EMIT: begin
				if (len == 3'd0) begin
					pc_d = (rem_q == '0) ? cw.jump : pc_q + 1'b1;
				end else if (can_load) begin
					load      = 1'b1;
					ld_symbol = i2r_pkg::symbol_of(cw.place,
						i2r_pkg::digit_kind(digit_q, char_q));
					ld_last   = char_end && (rem_q == '0);
					if (char_end) begin
						char_d = '0;
						pc_d   = (rem_q == '0) ? cw.jump : pc_q + 1'b1;
					end else begin
						char_d = char_q + 1'b1;
					end
				end
			end
			i2r_pkg::OP_ERROR: begin
				if (can_load) begin
					load      = 1'b1;
					ld_symbol = i2r_pkg::SYM_NONE;
					ld_last   = 1'b1;
					ld_bad    = 1'b1;
					pc_d      = cw.jump;
				end
			end
			default: begin
				pc_d = i2r_pkg::PC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= i2r_pkg::PC_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		rem_q   <= rem_d;
		digit_q <= digit_d;
		char_q  <= char_d;
		if (load) begin
			symbol_q <= ld_symbol;
			last_q   <= ld_last;
			bad_q    <= ld_bad;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;
	assign bad_input = bad_q;

endmodule

// ----- rtl/core/i2r_checker.sv -----
`include "assert_macros.svh"

module i2r_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [i2r_pkg::SYMBOL_W-1:0]  symbol,
	input logic                          last,
	input logic                          bad_input
);

	logic ok_char;

	assign ok_char = (symbol == i2r_pkg::SYM_I) || (symbol == i2r_pkg::SYM_V) ||
		(symbol == i2r_pkg::SYM_X) || (symbol == i2r_pkg::SYM_L) ||
		(symbol == i2r_pkg::SYM_C) || (symbol == i2r_pkg::SYM_D) ||
		(symbol == i2r_pkg::SYM_M);

	// error transfer is alone and empty
	`CHK_ASSERT(a_bad_shape, clk, arst_n, out_valid && bad_input,
		last && (symbol == i2r_pkg::SYM_NONE))
	// good transfers carry a numeral character
	`CHK_ASSERT(a_char_code, clk, arst_n, out_valid && !bad_input, ok_char)
	// one item at a time: input closes after a transfer
	`CHK_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)
	// stalled output holds
	`CHK_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(symbol) && $stable(last) && $stable(bad_input))

endmodule

bind integer_to_roman_encoder_top i2r_checker u_i2r_checker (.*);
